@@ design/action_track_smoother_defines.svh @@
// Assertion helpers shared by the smoother's modules.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef ACTION_TRACK_SMOOTHER_DEFINES_SVH
`define ACTION_TRACK_SMOOTHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smoother check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smoother check failed one cycle later");

`endif

@@ design/ats_pkg.sv @@
package ats_pkg;

   // Default field widths.
   localparam int FRAME_BITS_DEF    = 20;
   localparam int ACTION_BITS_DEF   = 8;
   localparam int TRACK_ID_BITS_DEF = 16;

   // The window and minimum length registers are always this wide.
   localparam int LEN_BITS = 11;

   // Reset values of the window and minimum length registers.
   localparam logic [LEN_BITS-1:0] WINDOW_RESET  = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] MIN_LEN_RESET = LEN_BITS'(1);

   // One request causes at most this many results.
   localparam int MAX_RESULTS = 3;
   localparam int RES_IDX_BITS = 2;

   // Register indexes on the configuration port.
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_FRM    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FINAL_FRM    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_JOIN_GAP     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEEP_LEN     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALLBACK_ACT = 3'd4;

   // Larger of two widths.
   function automatic int max_bits(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of the configuration write data: the widest register.
   function automatic int csr_bits(input int frame_bits, input int action_bits);
      return max_bits(max_bits(frame_bits + 1, LEN_BITS), action_bits);
   endfunction

endpackage

@@ design/ats_core.sv @@
module ats_core import ats_pkg::*; #(
   parameter int FRAME_BITS    = FRAME_BITS_DEF,
   parameter int ACTION_BITS   = ACTION_BITS_DEF,
   parameter int TRACK_ID_BITS = TRACK_ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Registered request and the strobe that consumes it.
   input  logic                      step,
   input  logic [TRACK_ID_BITS-1:0]  track_id,
   input  logic [FRAME_BITS-1:0]     frame_index,
   input  logic [ACTION_BITS-1:0]    action_code,
   input  logic                      last_in_track,
   // Configuration.
   input  logic [FRAME_BITS-1:0]     first_frm,
   input  logic [FRAME_BITS:0]       final_frm,
   input  logic [LEN_BITS-1:0]       join_gap,
   input  logic [LEN_BITS-1:0]       keep_len,
   input  logic [ACTION_BITS-1:0]    fallback_act,
   // Results caused by the current request, in order.
   output logic [RES_IDX_BITS-1:0]   res_count,
   output logic [TRACK_ID_BITS-1:0]  res_track [MAX_RESULTS],
   output logic [FRAME_BITS:0]       res_begin [MAX_RESULTS],
   output logic [FRAME_BITS:0]       res_end [MAX_RESULTS],
   output logic [ACTION_BITS-1:0]    res_action [MAX_RESULTS],
   output logic                      res_last [MAX_RESULTS]
);

   localparam int RB = FRAME_BITS + 1;
   localparam int SW = max_bits(RB, LEN_BITS) + 1;

   // Track state.
   logic [TRACK_ID_BITS-1:0] cur_track_ff, cur_track_in;
   logic [FRAME_BITS-1:0]    open_begin_ff, open_begin_in;
   logic [RB-1:0]            open_end_ff, open_end_in;
   logic [ACTION_BITS-1:0]   open_action_ff, open_action_in;
   logic                     open_valid_ff, open_valid_in;
   logic                     kept_any_ff, kept_any_in;
   logic [RB-1:0]            kept_end_ff, kept_end_in;
   logic [RB-1:0]            pend_begin_ff, pend_begin_in;
   logic [ACTION_BITS-1:0]   pend_action_ff, pend_action_in;

   // Intermediate values of the update.
   logic                     joined;
   logic                     close_first;
   logic                     do_close;
   logic [SW-1:0]            keep_limit;
   logic [RB:0]              mid_sum;
   logic [RB-1:0]            mid;
   logic [RB-1:0]            next_end;
   logic [RES_IDX_BITS-1:0]  cnt;

   // The join test looks at the stored range only; it does not change within a request.
   assign next_end    = RB'(frame_index) + RB'(1);
   assign joined      = (action_code == open_action_ff) &&
                        ((SW'(open_end_ff) + SW'(join_gap)) >= (SW'(frame_index) + SW'(1)));
   assign close_first = open_valid_ff && !joined;

   // Two passes: the first handles the event itself, the second the end of the track.
   always_comb begin
      cur_track_in   = cur_track_ff;
      open_begin_in  = open_begin_ff;
      open_end_in    = open_end_ff;
      open_action_in = open_action_ff;
      open_valid_in  = open_valid_ff;
      kept_any_in    = kept_any_ff;
      kept_end_in    = kept_end_ff;
      pend_begin_in  = pend_begin_ff;
      pend_action_in = pend_action_ff;
      do_close       = 1'b0;
      keep_limit     = '0;
      mid_sum        = '0;
      mid            = '0;
      cnt            = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res_track[k]  = '0;
         res_begin[k]  = '0;
         res_end[k]    = '0;
         res_action[k] = '0;
         res_last[k]   = 1'b0;
      end

      for (int p = 0; p < 2; p++) begin
         // A new track latches its id; a joining event stretches the open range.
         if (p == 0) begin
            if (!open_valid_ff) begin
               cur_track_in = track_id;
               kept_any_in  = 1'b0;
            end else if (joined) begin
               open_end_in = next_end;
            end
         end

         do_close = (p == 0) ? close_first : last_in_track;

         // Close the open range and keep it when it is long enough.
         if (do_close) begin
            keep_limit = SW'(open_begin_in) + SW'(keep_len);
            if (SW'(open_end_in) >= keep_limit) begin
               if (!kept_any_in) begin
                  kept_any_in    = 1'b1;
                  pend_begin_in  = RB'(first_frm);
                  pend_action_in = open_action_in;
                  kept_end_in    = open_end_in;
               end else begin
                  mid_sum     = (RB+1)'(open_begin_in) + (RB+1)'(kept_end_in);
                  mid         = mid_sum[RB:1];
                  kept_end_in = open_end_in;
                  if (open_action_in != pend_action_in) begin
                     res_track[cnt]  = cur_track_in;
                     res_begin[cnt]  = pend_begin_in;
                     res_end[cnt]    = mid;
                     res_action[cnt] = pend_action_in;
                     res_last[cnt]   = 1'b0;
                     cnt             = cnt + RES_IDX_BITS'(1);
                     pend_begin_in   = mid;
                     pend_action_in  = open_action_in;
                  end
               end
            end
         end

         // Start a range at this event unless it joined the open one.
         if (p == 0 && (!open_valid_ff || close_first)) begin
            open_begin_in  = frame_index;
            open_end_in    = next_end;
            open_action_in = action_code;
            open_valid_in  = 1'b1;
         end

         // The final range of the track runs to the configured end frame.
         if (p == 1 && last_in_track) begin
            res_track[cnt] = cur_track_in;
            res_end[cnt]   = final_frm;
            res_last[cnt]  = 1'b1;
            if (kept_any_in) begin
               res_begin[cnt]  = pend_begin_in;
               res_action[cnt] = pend_action_in;
            end else begin
               res_begin[cnt]  = RB'(first_frm);
               res_action[cnt] = fallback_act;
            end
            cnt           = cnt + RES_IDX_BITS'(1);
            open_valid_in = 1'b0;
            kept_any_in   = 1'b0;
         end
      end
      res_count = cnt;
   end

   // State update, one request per cycle while step is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_track_ff   <= '0;
         open_begin_ff  <= '0;
         open_end_ff    <= '0;
         open_action_ff <= '0;
         open_valid_ff  <= 1'b0;
         kept_any_ff    <= 1'b0;
         kept_end_ff    <= '0;
         pend_begin_ff  <= '0;
         pend_action_ff <= '0;
      end else if (step) begin
         cur_track_ff   <= cur_track_in;
         open_begin_ff  <= open_begin_in;
         open_end_ff    <= open_end_in;
         open_action_ff <= open_action_in;
         open_valid_ff  <= open_valid_in;
         kept_any_ff    <= kept_any_in;
         kept_end_ff    <= kept_end_in;
         pend_begin_ff  <= pend_begin_in;
         pend_action_ff <= pend_action_in;
      end
   end

endmodule

@@ design/action_track_smoother.sv @@
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid, req_stall | track id, frame index, action code, last flag
// rsp      | out       | rsp_valid, rsp_stall | track id, range begin, range end, action, last flag
// csr      | in        | csr_wr_en            | csr_index, csr_wdata (no read-back)
//
// A request is registered, then processed combinationally into a bank of up to three results.
// Requests flow at one per cycle while each causes at most one result and none is stalled;
// a request causing more results holds the next one until the output bank, which drains one
// result per cycle unless stalled, has sent its last. Results come from the registered bank.
// Reset is synchronous and clears the track state and the handshake control at once.
// A stalled result holds; the input register accepts when empty or the bank can be refilled.
`include "action_track_smoother_defines.svh"

module action_track_smoother import ats_pkg::*; #(
   parameter int FRAME_BITS    = FRAME_BITS_DEF,
   parameter int ACTION_BITS   = ACTION_BITS_DEF,
   parameter int TRACK_ID_BITS = TRACK_ID_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Request channel.
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [TRACK_ID_BITS-1:0]                   req_track_id,
   input  logic [FRAME_BITS-1:0]                      req_frame_index,
   input  logic [ACTION_BITS-1:0]                     req_action_code,
   input  logic                                       req_last_in_track,
   // Result channel.
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [TRACK_ID_BITS-1:0]                   rsp_out_track_id,
   output logic [FRAME_BITS:0]                        rsp_range_begin,
   output logic [FRAME_BITS:0]                        rsp_range_end,
   output logic [ACTION_BITS-1:0]                     rsp_range_action,
   output logic                                       rsp_last_of_track,
   // Configuration port.
   input  logic                                       csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]                    csr_index,
   input  logic [csr_bits(FRAME_BITS, ACTION_BITS)-1:0] csr_wdata
);

   localparam int RB = FRAME_BITS + 1;

   // Configuration registers.
   logic [FRAME_BITS-1:0]  first_frm_ff;
   logic [RB-1:0]          final_frm_ff;
   logic [LEN_BITS-1:0]    join_gap_ff;
   logic [LEN_BITS-1:0]    keep_len_ff;
   logic [ACTION_BITS-1:0] fallback_act_ff;

   // Input register.
   logic                     in_valid_ff;
   logic [TRACK_ID_BITS-1:0] in_track_ff;
   logic [FRAME_BITS-1:0]    in_frame_ff;
   logic [ACTION_BITS-1:0]   in_action_ff;
   logic                     in_last_ff;

   // Result bank.
   logic [TRACK_ID_BITS-1:0] bank_track_ff [MAX_RESULTS];
   logic [RB-1:0]            bank_begin_ff [MAX_RESULTS];
   logic [RB-1:0]            bank_end_ff [MAX_RESULTS];
   logic [ACTION_BITS-1:0]   bank_action_ff [MAX_RESULTS];
   logic                     bank_last_ff [MAX_RESULTS];
   logic [RES_IDX_BITS-1:0]  cnt_ff;
   logic [RES_IDX_BITS-1:0]  rd_ff;

   // Core results for the request in the input register.
   logic [RES_IDX_BITS-1:0]  res_count;
   logic [TRACK_ID_BITS-1:0] res_track [MAX_RESULTS];
   logic [RB-1:0]            res_begin [MAX_RESULTS];
   logic [RB-1:0]            res_end [MAX_RESULTS];
   logic [ACTION_BITS-1:0]   res_action [MAX_RESULTS];
   logic                     res_last [MAX_RESULTS];

   logic pop;
   logic last_slot;
   logic proc;
   logic req_take;

   // The bank can be refilled when empty or when its final result leaves now.
   assign pop       = rsp_valid && !rsp_stall;
   assign last_slot = (rd_ff + RES_IDX_BITS'(1)) == cnt_ff;
   assign proc      = in_valid_ff && ((cnt_ff == '0) || (pop && last_slot));
   assign req_stall = in_valid_ff && !proc;
   assign req_take  = req_valid && !req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_frm_ff    <= '0;
         final_frm_ff    <= '0;
         join_gap_ff     <= WINDOW_RESET;
         keep_len_ff     <= MIN_LEN_RESET;
         fallback_act_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_FRM:    first_frm_ff    <= csr_wdata[FRAME_BITS-1:0];
            CSR_FINAL_FRM:    final_frm_ff    <= csr_wdata[RB-1:0];
            CSR_JOIN_GAP:     join_gap_ff     <= csr_wdata[LEN_BITS-1:0];
            CSR_KEEP_LEN:     keep_len_ff     <= csr_wdata[LEN_BITS-1:0];
            CSR_FALLBACK_ACT: fallback_act_ff <= csr_wdata[ACTION_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_track_ff  <= req_track_id;
         in_frame_ff  <= req_frame_index;
         in_action_ff <= req_action_code;
         in_last_ff   <= req_last_in_track;
      end
   end

   ats_core #(
      .FRAME_BITS    (FRAME_BITS),
      .ACTION_BITS   (ACTION_BITS),
      .TRACK_ID_BITS (TRACK_ID_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (proc),
      .track_id       (in_track_ff),
      .frame_index    (in_frame_ff),
      .action_code    (in_action_ff),
      .last_in_track  (in_last_ff),
      .first_frm      (first_frm_ff),
      .final_frm      (final_frm_ff),
      .join_gap       (join_gap_ff),
      .keep_len       (keep_len_ff),
      .fallback_act   (fallback_act_ff),
      .res_count      (res_count),
      .res_track      (res_track),
      .res_begin      (res_begin),
      .res_end        (res_end),
      .res_action     (res_action),
      .res_last       (res_last)
   );

   // Bank fill and drain control.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else if (proc) begin
         cnt_ff <= res_count;
         rd_ff  <= '0;
      end else if (pop) begin
         if (last_slot) begin
            cnt_ff <= '0;
            rd_ff  <= '0;
         end else begin
            rd_ff <= rd_ff + RES_IDX_BITS'(1);
         end
      end
   end

   // Bank payload.
   always_ff @(posedge clock) begin
      if (proc) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            bank_track_ff[k]  <= res_track[k];
            bank_begin_ff[k]  <= res_begin[k];
            bank_end_ff[k]    <= res_end[k];
            bank_action_ff[k] <= res_action[k];
            bank_last_ff[k]   <= res_last[k];
         end
      end
   end

   // Result channel.
   assign rsp_valid         = cnt_ff != '0;
   assign rsp_out_track_id  = bank_track_ff[rd_ff];
   assign rsp_range_begin   = bank_begin_ff[rd_ff];
   assign rsp_range_end     = bank_end_ff[rd_ff];
   assign rsp_range_action  = bank_action_ff[rd_ff];
   assign rsp_last_of_track = bank_last_ff[rd_ff];

   // The read slot always lies inside the filled part of the bank.
   `ATS_ASSERT_NOW(a_rd_in_bank, cnt_ff != '0, rd_ff < cnt_ff)
   // A track's closing range is always the last result of its request.
   `ATS_ASSERT_NOW(a_last_is_final, rsp_valid && rsp_last_of_track, last_slot)
   // Processing the end of a track always leaves at least one result.
   `ATS_ASSERT_NEXT(a_track_end_emits, proc && in_last_ff, cnt_ff != '0)
   // A request is never taken while the input register holds one that cannot move.
   `ATS_ASSERT_NEXT(a_no_overwrite, in_valid_ff && !proc, in_valid_ff)

endmodule
